@@ hdl/optimal_merge_cost_macros.svh @@
// Assertion macros shared by the optimal merge cost block.
`ifndef OPTIMAL_MERGE_COST_MACROS_SVH
`define OPTIMAL_MERGE_COST_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define OMC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("optimal_merge_cost: same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define OMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("optimal_merge_cost: next-cycle check failed");

`endif

@@ hdl/omc_pkg.sv @@
// Package with the types, constants and control store of the optimal merge cost block.
`timescale 1ns / 1ps
package omc_pkg;

   localparam int MAX_FILES = 32;
   localparam int SIZE_BITS = 16;
   localparam int IDX_W     = $clog2(MAX_FILES);
   localparam int CNT_W     = $clog2(MAX_FILES + 1);
   localparam int FSIZE_W   = 16;
   localparam int REC_W     = 21;
   localparam int COST_W    = 26;
   localparam int PC_W      = 3;

   localparam logic [FSIZE_W-1:0] SIZE_MASK =
      FSIZE_W'((17'(1) << ((SIZE_BITS >= FSIZE_W) ? FSIZE_W : SIZE_BITS)) - 17'(1));

   typedef struct packed {
      logic [FSIZE_W-1:0] file_size;
      logic               last;
   } req_type;

   typedef struct packed {
      logic [COST_W-1:0] total_cost;
      logic [REC_W-1:0]  total_records;
      logic              overflow;
   } rsp_type;

   typedef enum logic [1:0] {
      RD_ZERO = 2'd0,
      RD_PTR  = 2'd1,
      RD_LAST = 2'd2
   } rd_sel_type;

   typedef enum logic [1:0] {
      PTR_HOLD = 2'd0,
      PTR_ONE  = 2'd1,
      PTR_INC  = 2'd2
   } ptr_op_type;

   typedef enum logic [1:0] {
      WR_NONE = 2'd0,
      WR_SUM  = 2'd1,
      WR_MOVE = 2'd2
   } wr_op_type;

   typedef enum logic [1:0] {
      JMP_NEXT   = 2'd0,
      JMP_SINGLE = 2'd1,
      JMP_MORE   = 2'd2,
      JMP_ALWAYS = 2'd3
   } jmp_type;

   localparam logic [PC_W-1:0] STEP_START = 3'd0;
   localparam logic [PC_W-1:0] STEP_SCAN  = 3'd1;
   localparam logic [PC_W-1:0] STEP_TAIL  = 3'd2;
   localparam logic [PC_W-1:0] STEP_SUM   = 3'd3;
   localparam logic [PC_W-1:0] STEP_MOVE  = 3'd4;
   localparam logic [PC_W-1:0] STEP_DONE  = 3'd5;

   typedef struct packed {
      rd_sel_type      rd_sel;
      ptr_op_type      ptr_op;
      logic            min_clr;
      logic            cmp_en;
      wr_op_type       wr_op;
      logic            acc_en;
      logic            cnt_dec;
      logic            done;
      jmp_type         jmp;
      logic [PC_W-1:0] target;
   } ctrl_type;

   typedef struct packed {
      logic single;
      logic more;
   } status_type;

   localparam ctrl_type CTRL_IDLE = '{
      rd_sel: RD_ZERO, ptr_op: PTR_HOLD, min_clr: 1'b0, cmp_en: 1'b0,
      wr_op: WR_NONE, acc_en: 1'b0, cnt_dec: 1'b0, done: 1'b0,
      jmp: JMP_NEXT, target: STEP_START};

   function automatic ctrl_type ucode(input logic [PC_W-1:0] pc);
      ctrl_type c;
      c = CTRL_IDLE;
      unique case (pc)
         STEP_START: begin
            c.rd_sel  = RD_ZERO;
            c.ptr_op  = PTR_ONE;
            c.min_clr = 1'b1;
            c.jmp     = JMP_SINGLE;
            c.target  = STEP_DONE;
         end
         STEP_SCAN: begin
            c.rd_sel = RD_PTR;
            c.ptr_op = PTR_INC;
            c.cmp_en = 1'b1;
            c.jmp    = JMP_MORE;
            c.target = STEP_SCAN;
         end
         STEP_TAIL: begin
            c.rd_sel = RD_LAST;
            c.cmp_en = 1'b1;
         end
         STEP_SUM: begin
            c.rd_sel = RD_LAST;
            c.wr_op  = WR_SUM;
            c.acc_en = 1'b1;
         end
         STEP_MOVE: begin
            c.rd_sel  = RD_LAST;
            c.wr_op   = WR_MOVE;
            c.cnt_dec = 1'b1;
            c.jmp     = JMP_ALWAYS;
            c.target  = STEP_START;
         end
         STEP_DONE: begin
            c.done = 1'b1;
         end
         default: begin
            c = CTRL_IDLE;
         end
      endcase
      return c;
   endfunction

endpackage

@@ hdl/omc_sequencer.sv @@
// Microprogram sequencer: step counter, control store lookup and conditional jumps.
`timescale 1ns / 1ps
module omc_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  logic                launch,
   input  omc_pkg::status_type status,
   output omc_pkg::ctrl_type   ctrl,
   output logic                busy
);
   import omc_pkg::*;

   logic [PC_W-1:0] pc_ff, pc_in;
   logic            busy_ff, busy_in;
   logic            take;

   always_comb begin
      ctrl = busy_ff ? ucode(pc_ff) : CTRL_IDLE;
   end

   always_comb begin
      unique case (ctrl.jmp)
         JMP_NEXT:   take = 1'b0;
         JMP_SINGLE: take = status.single;
         JMP_MORE:   take = status.more;
         JMP_ALWAYS: take = 1'b1;
         default:    take = 1'b0;
      endcase
   end

   always_comb begin
      pc_in   = pc_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         pc_in = take ? ctrl.target : pc_ff + PC_W'(1);
         if (ctrl.done) begin
            busy_in = 1'b0;
         end
      end else if (launch) begin
         pc_in   = STEP_START;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= STEP_START;
         busy_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         busy_ff <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

@@ hdl/omc_datapath.sv @@
// Datapath: size table memory, two-minimum scan, merge adder, cost accumulator and result register.
`timescale 1ns / 1ps
module omc_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  omc_pkg::req_type    req_word,
   input  omc_pkg::ctrl_type   ctrl,
   output omc_pkg::status_type status,
   output logic                rsp_strobe,
   output omc_pkg::rsp_type    rsp_word
);
   import omc_pkg::*;

   logic [REC_W-1:0]  mem [MAX_FILES];
   logic [REC_W-1:0]  rd_data_ff;
   logic [IDX_W-1:0]  rd_addr_ff, rd_addr;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic [CNT_W-1:0]  count_m1;
   logic [IDX_W-1:0]  last_idx;
   logic [REC_W:0]    min1_ff, min1_in, min2_ff, min2_in;
   logic [IDX_W-1:0]  idx1_ff, idx1_in, idx2_ff, idx2_in;
   logic [IDX_W-1:0]  lo_idx, hi_idx;
   logic [REC_W:0]    pair_sum;
   logic [REC_W-1:0]  merged;
   logic [COST_W:0]   cost_sum;
   logic [COST_W-1:0] acc_ff, acc_in;
   logic              ovf_ff, ovf_in;
   logic              strobe_ff;
   rsp_type           rsp_ff;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [REC_W-1:0]  wr_data;
   logic              has_room;

   assign count_m1 = count_ff - CNT_W'(1);
   assign last_idx = count_m1[IDX_W-1:0];
   assign has_room = count_ff < CNT_W'(MAX_FILES);

   always_comb begin
      unique case (ctrl.rd_sel)
         RD_ZERO: rd_addr = '0;
         RD_PTR:  rd_addr = ptr_ff[IDX_W-1:0];
         RD_LAST: rd_addr = last_idx;
         default: rd_addr = '0;
      endcase
   end

   assign lo_idx   = (idx1_ff < idx2_ff) ? idx1_ff : idx2_ff;
   assign hi_idx   = (idx1_ff < idx2_ff) ? idx2_ff : idx1_ff;
   assign pair_sum = (REC_W + 1)'(min1_ff[REC_W-1:0]) + (REC_W + 1)'(min2_ff[REC_W-1:0]);
   assign merged   = pair_sum[REC_W] ? '1 : pair_sum[REC_W-1:0];
   assign cost_sum = (COST_W + 1)'(acc_ff) + (COST_W + 1)'(merged);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[IDX_W-1:0];
      wr_data = REC_W'(req_word.file_size & SIZE_MASK);
      if (load) begin
         wr_en = has_room;
      end else begin
         unique case (ctrl.wr_op)
            WR_NONE: wr_en = 1'b0;
            WR_SUM: begin
               wr_en   = 1'b1;
               wr_addr = lo_idx;
               wr_data = merged;
            end
            WR_MOVE: begin
               wr_en   = hi_idx != last_idx;
               wr_addr = hi_idx;
               wr_data = rd_data_ff;
            end
            default: wr_en = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
      rd_addr_ff <= rd_addr;
   end

   always_comb begin
      min1_in = min1_ff;
      min2_in = min2_ff;
      idx1_in = idx1_ff;
      idx2_in = idx2_ff;
      if (ctrl.min_clr) begin
         min1_in = (REC_W + 1)'(1) << REC_W;
         min2_in = (REC_W + 1)'(1) << REC_W;
      end else if (ctrl.cmp_en) begin
         priority if ({1'b0, rd_data_ff} < min1_ff) begin
            min2_in = min1_ff;
            idx2_in = idx1_ff;
            min1_in = {1'b0, rd_data_ff};
            idx1_in = rd_addr_ff;
         end else if ({1'b0, rd_data_ff} < min2_ff) begin
            min2_in = {1'b0, rd_data_ff};
            idx2_in = rd_addr_ff;
         end
      end
   end

   always_comb begin
      unique case (ctrl.ptr_op)
         PTR_HOLD: ptr_in = ptr_ff;
         PTR_ONE:  ptr_in = CNT_W'(1);
         PTR_INC:  ptr_in = ptr_ff + CNT_W'(1);
         default:  ptr_in = ptr_ff;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      acc_in   = acc_ff;
      ovf_in   = ovf_ff;
      if (load) begin
         if (has_room) begin
            count_in = count_ff + CNT_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (ctrl.cnt_dec) begin
         count_in = count_m1;
      end
      if (ctrl.acc_en) begin
         acc_in = cost_sum[COST_W] ? '1 : cost_sum[COST_W-1:0];
      end
      if (ctrl.done) begin
         count_in = '0;
         acc_in   = '0;
         ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         acc_ff    <= '0;
         ovf_ff    <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         acc_ff    <= acc_in;
         ovf_ff    <= ovf_in;
         strobe_ff <= ctrl.done;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff  <= ptr_in;
      min1_ff <= min1_in;
      min2_ff <= min2_in;
      idx1_ff <= idx1_in;
      idx2_ff <= idx2_in;
      if (ctrl.done) begin
         rsp_ff.total_cost    <= acc_ff;
         rsp_ff.total_records <= rd_data_ff;
         rsp_ff.overflow      <= ovf_ff;
      end
   end

   assign status.single = count_ff <= CNT_W'(1);
   assign status.more   = (ptr_ff + CNT_W'(1)) < count_ff;
   assign rsp_strobe    = strobe_ff;
   assign rsp_word      = rsp_ff;

endmodule

@@ hdl/optimal_merge_cost.sv @@
// Optimal merge cost: loads file sizes, then merges the two smallest entries under microcode.
// Words load one per cycle while idle; a word without last is followed by the next at once.
// After the last word, each merge scans the one-port table for the two smallest entries, sums
// them into one slot and moves the last entry to the other until one is left, then rsp_strobe.
// busy is high for the whole merge phase; rsp_strobe is a one-cycle strobe and rsp_word holds.
// Synchronous reset clears the count, cost, overflow flag and sequencer; the table is not cleared.
`timescale 1ns / 1ps
module optimal_merge_cost (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  omc_pkg::req_type req_word,
   output logic             rsp_strobe,
   output omc_pkg::rsp_type rsp_word
);
   import omc_pkg::*;

   `include "optimal_merge_cost_macros.svh"

   ctrl_type   ctrl;
   status_type status;
   logic       load;
   logic       launch;

   assign load   = start && !busy;
   assign launch = load && req_word.last;

   omc_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .launch (launch),
      .status (status),
      .ctrl   (ctrl),
      .busy   (busy)
   );

   omc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .req_word   (req_word),
      .ctrl       (ctrl),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   `OMC_ASSERT_NEXT(a_launch_busy, clock, reset, launch, busy)
   `OMC_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_strobe, !busy)
   `OMC_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe)

endmodule
